// File: sv/tcm_pkg.sv
package tcm_pkg;

  localparam int DEF_SECTIONS = 7;
  localparam int CORNERS      = 8;
  localparam int WORDS        = 3;
  localparam int WORD_W       = 16;
  localparam int TAG_W        = 3;
  localparam int COORD_W      = 17;
  localparam int T_W          = 16;
  localparam int PROD_W       = 34;
  localparam int FRAC_W       = 15;
  localparam logic [T_W-1:0] ONE_Q15 = 16'd32768;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_INTERP = 1'b1;

  localparam logic [1:0] FIELD_FREQ = 2'd0;
  localparam logic [1:0] FIELD_RESO = 2'd1;
  localparam logic [1:0] FIELD_GAIN = 2'd2;
  localparam logic [1:0] FIELD_TYPE = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic latch;
    logic issue;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic advance;
    logic busy;
  } status_t;

  function automatic logic [T_W-1:0] clamp_coord(logic signed [COORD_W-1:0] v);
    logic [T_W-1:0] r;
    if (v[COORD_W-1]) begin
      r = '0;
    end else if (v > $signed({1'b0, ONE_Q15})) begin
      r = ONE_Q15;
    end else begin
      r = v[T_W-1:0];
    end
    return r;
  endfunction

  // (b - a) * t, t unsigned in 0..1.0
  function automatic logic signed [PROD_W-1:0] lerp_prod(logic signed [WORD_W-1:0] a,
                                                         logic signed [WORD_W-1:0] b,
                                                         logic [T_W-1:0] t);
    logic signed [WORD_W:0] d;
    logic signed [T_W:0]    ts;
    d  = (WORD_W+1)'(b) - (WORD_W+1)'(a);
    ts = $signed({1'b0, t});
    return PROD_W'(d) * PROD_W'(ts);
  endfunction

  // arithmetic shift floors toward minus infinity; the sum stays between a and b
  function automatic logic signed [WORD_W-1:0] lerp_sum(logic signed [WORD_W-1:0] a,
                                                        logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = p >>> FRAC_W;
    return WORD_W'(PROD_W'(a) + q);
  endfunction

endpackage

// File: sv/tcm_ctrl.sv
module tcm_ctrl #(
  parameter int SECTIONS = tcm_pkg::DEF_SECTIONS,
  parameter int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             action,
  input  logic [2:0]       section,
  output tcm_pkg::cmd_t    cmd,
  output logic [SEC_W-1:0] cmd_sec,
  input  tcm_pkg::status_t status
);

  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);

  tcm_pkg::state_t  state, state_next;
  logic [SEC_W-1:0] cnt, cnt_next;
  logic             sec_ok;

  assign sec_ok = (32'(section) < SECTIONS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcm_pkg::ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd_sec    = cnt;
    in_stall   = 1'b1;
    unique case (state)
      tcm_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (cnt == LAST_SEC) begin
          cnt_next   = '0;
          state_next = tcm_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tcm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (action == tcm_pkg::ACTION_LOAD) begin
            // drop loads aimed past the table
            cmd.load = sec_ok;
          end else begin
            cmd.latch  = 1'b1;
            cnt_next   = '0;
            state_next = tcm_pkg::ST_RUN;
          end
        end
      end
      tcm_pkg::ST_RUN: begin
        if (status.advance) begin
          cmd.issue = 1'b1;
          cmd.last  = (cnt == LAST_SEC);
          if (cnt == LAST_SEC) begin
            cnt_next   = '0;
            state_next = tcm_pkg::ST_DRAIN;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      tcm_pkg::ST_DRAIN: begin
        if (!status.busy) begin
          state_next = tcm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/tcm_datapath.sv
module tcm_datapath #(
  parameter int SECTIONS = tcm_pkg::DEF_SECTIONS,
  parameter int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tcm_pkg::cmd_t               cmd,
  input  logic [SEC_W-1:0]            cmd_sec,
  output tcm_pkg::status_t            status,
  input  logic [2:0]                  corner,
  input  logic [2:0]                  section,
  input  logic [1:0]                  field_select,
  input  logic signed [15:0]          load_value,
  input  logic signed [16:0]          x_pos,
  input  logic signed [16:0]          y_pos,
  input  logic signed [16:0]          z_pos,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_section,
  output logic signed [15:0]          freq_word,
  output logic signed [15:0]          reso_word,
  output logic signed [15:0]          gain_word,
  output logic [2:0]                  section_type,
  output logic                        last
);

  localparam int W     = tcm_pkg::WORD_W;
  localparam int NW    = tcm_pkg::WORDS;
  localparam int ROW_W = tcm_pkg::CORNERS * NW * W;
  localparam int SLOT_W = $clog2(tcm_pkg::CORNERS * NW);
  localparam int STAGES = 7;

  // one row per section: all corners and words side by side
  logic [ROW_W-1:0]          mem [SECTIONS];
  logic [tcm_pkg::TAG_W-1:0] tags [SECTIONS];

  logic [tcm_pkg::T_W-1:0] xt, yt, zt;
  logic [SEC_W-1:0]        wr_sec;
  logic [SLOT_W-1:0]       slot;
  logic                    en;

  logic [STAGES-1:0]         v;
  logic [SEC_W-1:0]          m_sec  [STAGES];
  logic [tcm_pkg::TAG_W-1:0] m_tag  [STAGES];
  logic                      m_last [STAGES];

  logic [ROW_W-1:0]                   rd_row;
  logic signed [tcm_pkg::PROD_W-1:0]  p1 [NW][4];
  logic signed [W-1:0]                a1 [NW][4];
  logic signed [W-1:0]                r1 [NW][4];
  logic signed [tcm_pkg::PROD_W-1:0]  p2 [NW][2];
  logic signed [W-1:0]                a2 [NW][2];
  logic signed [W-1:0]                r2 [NW][2];
  logic signed [tcm_pkg::PROD_W-1:0]  p3 [NW];
  logic signed [W-1:0]                a3 [NW];
  logic signed [W-1:0]                res [NW];

  assign wr_sec = SEC_W'(section);
  assign slot   = SLOT_W'(corner * NW) + SLOT_W'(field_select);
  assign en     = !v[STAGES-1] || !out_stall;

  assign status.advance = en;
  assign status.busy    = |v;

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[cmd_sec] <= '0;
    end else if (cmd.load && field_select != tcm_pkg::FIELD_TYPE) begin
      mem[wr_sec][slot*W +: W] <= load_value;
    end
    if (cmd.issue && en) begin
      rd_row <= mem[cmd_sec];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SECTIONS; s++) begin
        tags[s] <= '0;
      end
    end else if (cmd.load && field_select == tcm_pkg::FIELD_TYPE) begin
      tags[wr_sec] <= load_value[tcm_pkg::TAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      xt <= tcm_pkg::clamp_coord(x_pos);
      yt <= tcm_pkg::clamp_coord(y_pos);
      zt <= tcm_pkg::clamp_coord(z_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-2:0], cmd.issue};
    end
  end

  // whole pipe holds while the output register is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      m_sec[0]  <= cmd_sec;
      m_tag[0]  <= tags[cmd_sec];
      m_last[0] <= cmd.last;
      for (int i = 1; i < STAGES; i++) begin
        m_sec[i]  <= m_sec[i-1];
        m_tag[i]  <= m_tag[i-1];
        m_last[i] <= m_last[i-1];
      end
      for (int w = 0; w < NW; w++) begin
        for (int k = 0; k < 4; k++) begin
          a1[w][k] <= rd_row[((2*k)*NW + w)*W +: W];
          p1[w][k] <= tcm_pkg::lerp_prod(rd_row[((2*k)*NW + w)*W +: W],
                                         rd_row[((2*k+1)*NW + w)*W +: W], xt);
          r1[w][k] <= tcm_pkg::lerp_sum(a1[w][k], p1[w][k]);
        end
        for (int j = 0; j < 2; j++) begin
          a2[w][j] <= r1[w][2*j];
          p2[w][j] <= tcm_pkg::lerp_prod(r1[w][2*j], r1[w][2*j+1], yt);
          r2[w][j] <= tcm_pkg::lerp_sum(a2[w][j], p2[w][j]);
        end
        a3[w]  <= r2[w][0];
        p3[w]  <= tcm_pkg::lerp_prod(r2[w][0], r2[w][1], zt);
        res[w] <= tcm_pkg::lerp_sum(a3[w], p3[w]);
      end
    end
  end

  assign out_valid    = v[STAGES-1];
  assign out_section  = 3'(m_sec[STAGES-1]);
  assign section_type = m_tag[STAGES-1];
  assign last         = m_last[STAGES-1];
  assign freq_word    = res[tcm_pkg::FIELD_FREQ];
  assign reso_word    = res[tcm_pkg::FIELD_RESO];
  assign gain_word    = res[tcm_pkg::FIELD_GAIN];

endmodule

// File: sv/trilinear_coefficient_morph_unit.sv
// Load item: no result. Interpolate item: results follow the transfer, one section
// per cycle while the output does not stall, through the seven-stage lerp pipe (x, y, z levels).
// The next item is taken once the pipe has drained; an output stall holds the whole pipe.
// Reset (rst, synchronous) starts a clearing pass, one section row per cycle, during
// which input is stalled; type tags clear at once.
module trilinear_coefficient_morph_unit #(
  parameter int SECTIONS = tcm_pkg::DEF_SECTIONS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [2:0]         corner,
  input  logic [2:0]         section,
  input  logic [1:0]         field_select,
  input  logic signed [15:0] load_value,
  input  logic signed [16:0] x_pos,
  input  logic signed [16:0] y_pos,
  input  logic signed [16:0] z_pos,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_section,
  output logic signed [15:0] freq_word,
  output logic signed [15:0] reso_word,
  output logic signed [15:0] gain_word,
  output logic [2:0]         section_type,
  output logic               last
);

  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

  tcm_pkg::cmd_t    cmd;
  tcm_pkg::status_t status;
  logic [SEC_W-1:0] cmd_sec;

  tcm_ctrl #(
    .SECTIONS (SECTIONS),
    .SEC_W    (SEC_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .section  (section),
    .cmd      (cmd),
    .cmd_sec  (cmd_sec),
    .status   (status)
  );

  tcm_datapath #(
    .SECTIONS (SECTIONS),
    .SEC_W    (SEC_W)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cmd_sec      (cmd_sec),
    .status       (status),
    .corner       (corner),
    .section      (section),
    .field_select (field_select),
    .load_value   (load_value),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .z_pos        (z_pos),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_section  (out_section),
    .freq_word    (freq_word),
    .reso_word    (reso_word),
    .gain_word    (gain_word),
    .section_type (section_type),
    .last         (last)
  );

endmodule

// File: tb/sv/trilinear_coefficient_morph_unit_tb.sv
module trilinear_coefficient_morph_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SEC      = tcm_pkg::DEF_SECTIONS;
  localparam int ONE_T      = 32768;
  localparam int LONG_HOLD  = 400;
  localparam int RAND_ITEMS = 230;

  typedef struct {
    logic [2:0]         sec;
    logic signed [15:0] freq;
    logic signed [15:0] reso;
    logic signed [15:0] gain;
    logic [2:0]         tag;
    logic               last;
  } section_result_t;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY
  } rx_mode_t;

  class morph_tracker;
    int              cube [tcm_pkg::CORNERS][N_SEC][tcm_pkg::WORDS];
    logic [2:0]      tags [N_SEC];
    section_result_t due_sections [$];
    int              faults;

    function new();
      foreach (cube[c, s, w]) cube[c][s][w] = 0;
      foreach (tags[s]) tags[s] = '0;
      faults = 0;
    endfunction

    // a + floor((b - a) * t / 2^15)
    function int blend(int a, int b, int t);
      longint p;
      p = longint'(b - a) * longint'(t);
      return a + int'(p >>> tcm_pkg::FRAC_W);
    endfunction

    function int clamp_q15(logic signed [16:0] v);
      int c;
      c = int'(v);
      if (c < 0) c = 0;
      if (c > ONE_T) c = ONE_T;
      return c;
    endfunction

    function int cube_blend(int s, int w, int x, int y, int z);
      int c00, c10, c01, c11;
      c00 = blend(cube[0][s][w], cube[1][s][w], x);
      c10 = blend(cube[2][s][w], cube[3][s][w], x);
      c01 = blend(cube[4][s][w], cube[5][s][w], x);
      c11 = blend(cube[6][s][w], cube[7][s][w], x);
      return blend(blend(c00, c10, y), blend(c01, c11, y), z);
    endfunction

    function void note_item(logic act, logic [2:0] corner, logic [2:0] sec,
                            logic [1:0] fsel, logic signed [15:0] value,
                            logic signed [16:0] xp, logic signed [16:0] yp,
                            logic signed [16:0] zp);
      int x, y, z;
      section_result_t r;
      if (act == tcm_pkg::ACTION_LOAD) begin
        if (sec >= N_SEC) return;
        if (fsel == tcm_pkg::FIELD_TYPE) tags[sec] = value[2:0];
        else cube[corner][sec][fsel] = int'(value);
        return;
      end
      x = clamp_q15(xp);
      y = clamp_q15(yp);
      z = clamp_q15(zp);
      for (int s = 0; s < N_SEC; s++) begin
        r.sec  = 3'(s);
        r.freq = 16'(cube_blend(s, int'(tcm_pkg::FIELD_FREQ), x, y, z));
        r.reso = 16'(cube_blend(s, int'(tcm_pkg::FIELD_RESO), x, y, z));
        r.gain = 16'(cube_blend(s, int'(tcm_pkg::FIELD_GAIN), x, y, z));
        r.tag  = tags[s];
        r.last = (s == N_SEC - 1);
        due_sections.push_back(r);
      end
    endfunction

    function void check_section(section_result_t got);
      section_result_t want;
      if (due_sections.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected result: sec %0d freq %0d reso %0d gain %0d tag %0d last %0b",
                   $realtime, got.sec, got.freq, got.reso, got.gain, got.tag, got.last);
        return;
      end
      want = due_sections.pop_front();
      if (got.sec !== want.sec || got.freq !== want.freq || got.reso !== want.reso ||
          got.gain !== want.gain || got.tag !== want.tag || got.last !== want.last) begin
        faults++;
        if (faults <= 10) begin
          $display("%0t: mismatch: expected sec %0d freq %0d reso %0d gain %0d tag %0d last %0b",
                   $realtime, want.sec, want.freq, want.reso, want.gain, want.tag, want.last);
          $display("%0t:           actual   sec %0d freq %0d reso %0d gain %0d tag %0d last %0b",
                   $realtime, got.sec, got.freq, got.reso, got.gain, got.tag, got.last);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               action;
  logic [2:0]         corner;
  logic [2:0]         section;
  logic [1:0]         field_select;
  logic signed [15:0] load_value;
  logic signed [16:0] x_pos;
  logic signed [16:0] y_pos;
  logic signed [16:0] z_pos;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_section;
  logic signed [15:0] freq_word;
  logic signed [15:0] reso_word;
  logic signed [15:0] gain_word;
  logic [2:0]         section_type;
  logic               last;

  morph_tracker tracker;
  int           burst_left;
  bit           long_hold_go;

  trilinear_coefficient_morph_unit #(
    .SECTIONS(N_SEC)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .corner(corner),
    .section(section),
    .field_select(field_select),
    .load_value(load_value),
    .x_pos(x_pos),
    .y_pos(y_pos),
    .z_pos(z_pos),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_section(out_section),
    .freq_word(freq_word),
    .reso_word(reso_word),
    .gain_word(gain_word),
    .section_type(section_type),
    .last(last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #3_000_000;
    $display("[trilinear_coefficient_morph_unit] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    section_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.sec  = out_section;
      got.freq = freq_word;
      got.reso = reso_word;
      got.gain = gain_word;
      got.tag  = section_type;
      got.last = last;
      tracker.check_section(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(logic act, logic [2:0] c, logic [2:0] s, logic [1:0] f,
                           logic signed [15:0] v, logic signed [16:0] xp,
                           logic signed [16:0] yp, logic signed [16:0] zp);
    action       = act;
    corner       = c;
    section      = s;
    field_select = f;
    load_value   = v;
    x_pos        = xp;
    y_pos        = yp;
    z_pos        = zp;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_item(act, c, s, f, v, xp, yp, zp);
    @(negedge clk);
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic push_load(logic [2:0] c, logic [2:0] s, logic [1:0] f,
                           logic signed [15:0] v);
    push_item(tcm_pkg::ACTION_LOAD, c, s, f, v, 17'($urandom), 17'($urandom),
              17'($urandom));
  endtask

  task automatic push_interp(logic signed [16:0] xp, logic signed [16:0] yp,
                             logic signed [16:0] zp);
    push_item(tcm_pkg::ACTION_INTERP, 3'($urandom), 3'($urandom), 2'($urandom),
              16'($urandom), xp, yp, zp);
  endtask

  function automatic logic signed [16:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 17'sd0;
      1:       return 17'sd32768;
      2, 3:    return 17'($urandom);
      default: return 17'($urandom_range(0, ONE_T));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver stall pattern
  initial begin
    rx_mode_t mode;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 2));
      repeat ($urandom_range(10, 60)) begin
        case (mode)
          RX_FREE:  out_stall = 1'b0;
          RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          default:  out_stall = ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    int sent;
    logic [2:0] s;
    tracker      = new();
    long_hold_go = 1'b0;
    burst_left   = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = tcm_pkg::ACTION_LOAD;
    corner       = '0;
    section      = '0;
    field_select = tcm_pkg::FIELD_FREQ;
    load_value   = '0;
    x_pos        = '0;
    y_pos        = '0;
    z_pos        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // cleared store first, then extremes, stray type-tag corner and out-of-table loads
    push_interp(17'sd0, 17'sd0, 17'sd0);
    push_load(3'd0, 3'd0, tcm_pkg::FIELD_FREQ, 16'sh8000);
    push_load(3'd1, 3'd0, tcm_pkg::FIELD_FREQ, 16'sh7fff);
    push_load(3'd6, 3'd0, tcm_pkg::FIELD_RESO, 16'sh7fff);
    push_load(3'd7, 3'd0, tcm_pkg::FIELD_GAIN, 16'sh8000);
    push_load(3'd5, 3'd6, tcm_pkg::FIELD_TYPE, 16'shfffd);
    push_load(3'd0, 3'd3, tcm_pkg::FIELD_TYPE, 16'sh0002);
    push_load(3'd4, 3'd6, tcm_pkg::FIELD_GAIN, -16'sd1);
    push_load(3'd7, 3'd6, tcm_pkg::FIELD_FREQ, 16'sh7fff);
    push_load(3'd3, 3'd7, tcm_pkg::FIELD_FREQ, 16'sd1234);
    push_load(3'd2, 3'd7, tcm_pkg::FIELD_TYPE, 16'sh0003);
    push_interp(-17'sd65536, 17'sd65535, 17'sd32768);
    push_interp(17'sd32768, 17'sd0, -17'sd1);
    push_interp(17'sd1, 17'sd32767, 17'sd32769);
    push_interp(17'sd16384, 17'sd16384, 17'sd16384);
    push_interp(17'sd32768, 17'sd32768, 17'sd32768);
    push_interp(-17'sd1, 17'sd32767, 17'sd0);

    long_hold_go = 1'b1;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      pace_sender();
      if ($urandom_range(0, 99) < 45) begin
        s = ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, N_SEC - 1));
        push_load(3'($urandom), s, 2'($urandom), pick_word());
        if (s < N_SEC) sent++;
      end else begin
        push_interp(pick_coord(), pick_coord(), pick_coord());
        sent++;
      end
    end
    in_valid = 1'b0;

    while (tracker.due_sections.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.faults == 0 && tracker.due_sections.size() == 0) begin
      $display("[trilinear_coefficient_morph_unit] OK");
    end else begin
      $display("[trilinear_coefficient_morph_unit] ERROR");
    end
    $finish;
  end

endmodule
